>>> src/pulse_timestamp_pipeline_defines.svh
// Assertion macros for the timestamp pipeline RTL.
`ifndef PULSE_TIMESTAMP_PIPELINE_DEFINES_SVH
`define PULSE_TIMESTAMP_PIPELINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pts_pkg.sv
// Types and constants for the pulse timestamp pipeline.
package pts_pkg;

    localparam int SLOT_COUNT_DEF    = 4;
    localparam int PULSE_ID_BITS_DEF = 17;

    localparam int SECONDS_W = 32;
    localparam int NANOS_W   = 30;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    // Item opcodes; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_FIDUCIAL = 2'd1,
        KIND_READ     = 2'd2
    } kind_t;

    // Outcome of the pulse ID check
    typedef struct packed {
        logic err;
        logic same_hit;
        logic skip_hit;
        logic same_pulse;
    } check_t;

    // Update request to the slot file
    typedef struct packed {
        logic wr;
        logic shift;
        logic same_pulse;
    } slot_ctrl_t;

endpackage

>>> src/pts_check.sv
// Pulse ID consecutiveness check for fiducial words.
module pts_check #(
    parameter int PULSE_ID_BITS = pts_pkg::PULSE_ID_BITS_DEF
) (
    input  logic [PULSE_ID_BITS-1:0] pulse_newest,
    input  logic [PULSE_ID_BITS-1:0] pulse_ahead_two,
    input  logic [PULSE_ID_BITS-1:0] pulse_ahead_one,
    input  logic [PULSE_ID_BITS-1:0] pulse_now,
    input  logic                     newest_bad,
    input  logic                     ahead_two_bad,
    input  logic                     ahead_one_bad,
    output pts_pkg::check_t          result
);
    import pts_pkg::*;

    localparam logic [PULSE_ID_BITS-1:0] ONE = PULSE_ID_BITS'(1);

    logic [PULSE_ID_BITS-1:0] diff_newest;
    logic [PULSE_ID_BITS-1:0] diff_ahead;
    logic                     any_bad;
    logic                     newest_follows;
    logic                     ahead_follows;

    // Differences wrap at the ID width, so rollover counts as consecutive
    always_comb
    begin
        diff_newest    = pulse_newest - pulse_ahead_two;
        diff_ahead     = pulse_ahead_two - pulse_ahead_one;
        any_bad        = newest_bad | ahead_two_bad | ahead_one_bad;
        newest_follows = (diff_newest == ONE);
        ahead_follows  = (diff_ahead == ONE);

        result.err        = any_bad | ~newest_follows | ~ahead_follows;
        result.same_hit   = ~any_bad & ~newest_follows & (pulse_newest == pulse_ahead_two);
        result.skip_hit   = ~any_bad & ~newest_follows & (pulse_newest != pulse_ahead_two);
        result.same_pulse = (pulse_now == pulse_ahead_one);
    end

endmodule

>>> src/pts_slots.sv
// Timestamp slot file: newest-slot write, shift toward current, slot read.
module pts_slots #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pts_pkg::slot_ctrl_t            ctrl,
    input  logic [pts_pkg::SECONDS_W-1:0]  wr_seconds,
    input  logic [pts_pkg::NANOS_W-1:0]    wr_nanos,
    input  logic [pts_pkg::STATUS_W-1:0]   wr_status,
    input  logic [IDX_W-1:0]               rd_idx,
    output logic [pts_pkg::SECONDS_W-1:0]  rd_seconds,
    output logic [pts_pkg::NANOS_W-1:0]    rd_nanos,
    output logic [pts_pkg::STATUS_W-1:0]   rd_status
);
    import pts_pkg::*;

    localparam int                RUN_W  = $clog2(SLOT_COUNT + 1);
    localparam logic [RUN_W-1:0]  RUN_MAX = RUN_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]  LAST   = IDX_W'(SLOT_COUNT - 1);

    logic [SECONDS_W-1:0] seconds_reg  [SLOT_COUNT];
    logic [SECONDS_W-1:0] seconds_next [SLOT_COUNT];
    logic [NANOS_W-1:0]   nanos_reg    [SLOT_COUNT];
    logic [NANOS_W-1:0]   nanos_next   [SLOT_COUNT];
    logic [STATUS_W-1:0]  status_reg   [SLOT_COUNT];
    logic [STATUS_W-1:0]  status_next  [SLOT_COUNT];
    logic [RUN_W-1:0]     run_reg;
    logic [RUN_W-1:0]     run_next;
    logic [IDX_W-1:0]     idx_clamped;

    // Next slot contents
    always_comb
    begin
        for (int n = 0; n < SLOT_COUNT; n++)
        begin
            seconds_next[n] = seconds_reg[n];
            nanos_next[n]   = nanos_reg[n];
            status_next[n]  = status_reg[n];
        end
        run_next = run_reg;

        if (ctrl.wr)
        begin
            seconds_next[SLOT_COUNT-1] = wr_seconds;
            nanos_next[SLOT_COUNT-1]   = wr_nanos;
            // code 3 is stored as invalid
            status_next[SLOT_COUNT-1]  = (wr_status > STATUS_INVALID) ? STATUS_INVALID
                                                                     : wr_status;
        end
        else if (ctrl.shift)
        begin
            // newest slot keeps its contents
            for (int n = 0; n < SLOT_COUNT - 1; n++)
            begin
                seconds_next[n] = seconds_reg[n+1];
                nanos_next[n]   = nanos_reg[n+1];
                status_next[n]  = status_reg[n+1];
            end
            // long run of repeated pulses invalidates the current slot
            if (ctrl.same_pulse)
            begin
                if (run_reg == RUN_MAX)
                begin
                    status_next[0] = STATUS_INVALID;
                end
                else
                begin
                    run_next = run_reg + RUN_W'(1);
                end
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < SLOT_COUNT; n++)
            begin
                seconds_reg[n] <= '0;
                nanos_reg[n]   <= '0;
                status_reg[n]  <= STATUS_INVALID;
            end
            run_reg <= '0;
        end
        else
        begin
            for (int n = 0; n < SLOT_COUNT; n++)
            begin
                seconds_reg[n] <= seconds_next[n];
                nanos_reg[n]   <= nanos_next[n];
                status_reg[n]  <= status_next[n];
            end
            run_reg <= run_next;
        end
    end

    // Read port; an index past the end reads the newest slot
    always_comb
    begin
        idx_clamped = (rd_idx > LAST) ? LAST : rd_idx;
        rd_seconds  = seconds_reg[idx_clamped];
        rd_nanos    = nanos_reg[idx_clamped];
        rd_status   = status_reg[idx_clamped];
    end

endmodule

>>> src/pulse_timestamp_pipeline.sv
// A word passes through the input register and then the result register; out_stall can hold it in between.
// Throughput: one word per cycle while out_stall is low; every word is finished in the single pass between them.
// While a result waits on out_stall, one more word can enter the input register.
// Reset (rst_n, async, active low): slots clear to zero with status invalid,
// the same-pulse run and both event counts clear, and both stages empty.
module pulse_timestamp_pipeline #(
    parameter int SLOT_COUNT    = pts_pkg::SLOT_COUNT_DEF,
    parameter int PULSE_ID_BITS = pts_pkg::PULSE_ID_BITS_DEF,
    parameter int IDX_W         = $clog2(SLOT_COUNT)
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [pts_pkg::SECONDS_W-1:0]  stamp_seconds,
    input  logic [pts_pkg::NANOS_W-1:0]    stamp_nanos,
    input  logic [pts_pkg::STATUS_W-1:0]   stamp_status,
    input  logic [PULSE_ID_BITS-1:0]       pulse_newest,
    input  logic [PULSE_ID_BITS-1:0]       pulse_ahead_two,
    input  logic [PULSE_ID_BITS-1:0]       pulse_ahead_one,
    input  logic [PULSE_ID_BITS-1:0]       pulse_now,
    input  logic                           newest_bad,
    input  logic                           ahead_two_bad,
    input  logic                           ahead_one_bad,
    input  logic [IDX_W-1:0]               slot_index,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pts_pkg::SECONDS_W-1:0]  read_seconds,
    output logic [pts_pkg::NANOS_W-1:0]    read_nanos,
    output logic [pts_pkg::STATUS_W-1:0]   read_status,
    output logic                           error_flag,
    output logic [pts_pkg::COUNT_W-1:0]    same_pulse_total,
    output logic [pts_pkg::COUNT_W-1:0]    skipped_pulse_total
);
    import pts_pkg::*;

    `include "pulse_timestamp_pipeline_defines.svh"

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // input stage
    logic                     in_valid_reg;
    logic [1:0]               kind_reg;
    logic [SECONDS_W-1:0]     seconds_reg;
    logic [NANOS_W-1:0]       nanos_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [PULSE_ID_BITS-1:0] newest_reg;
    logic [PULSE_ID_BITS-1:0] ahead_two_reg;
    logic [PULSE_ID_BITS-1:0] ahead_one_reg;
    logic [PULSE_ID_BITS-1:0] now_reg;
    logic                     newest_bad_reg;
    logic                     ahead_two_bad_reg;
    logic                     ahead_one_bad_reg;
    logic [IDX_W-1:0]         idx_reg;

    // working logic
    logic                     advance;
    logic                     in_take;
    logic                     is_write;
    logic                     is_fid;
    logic                     is_read;
    check_t                   chk;
    slot_ctrl_t               slot_ctrl;
    logic [SECONDS_W-1:0]     slot_seconds;
    logic [NANOS_W-1:0]       slot_nanos;
    logic [STATUS_W-1:0]      slot_status;

    // counters
    logic [COUNT_W-1:0]       same_total_reg;
    logic [COUNT_W-1:0]       same_total_next;
    logic [COUNT_W-1:0]       skip_total_reg;
    logic [COUNT_W-1:0]       skip_total_next;

    // result stage
    logic                     out_valid_reg;
    logic [SECONDS_W-1:0]     read_seconds_reg;
    logic [NANOS_W-1:0]       read_nanos_reg;
    logic [STATUS_W-1:0]      read_status_reg;
    logic                     error_flag_reg;
    logic [COUNT_W-1:0]       same_out_reg;
    logic [COUNT_W-1:0]       skip_out_reg;

    // Handshake: the held word moves on when the result register is free
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    // Opcode decode
    always_comb
    begin
        is_write = 1'b0;
        is_fid   = 1'b0;
        is_read  = 1'b0;
        unique case (kind_reg)
            KIND_WRITE:    is_write = 1'b1;
            KIND_FIDUCIAL: is_fid   = 1'b1;
            KIND_READ:     is_read  = 1'b1;
            default:       ;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg          <= kind;
            seconds_reg       <= stamp_seconds;
            nanos_reg         <= stamp_nanos;
            status_reg        <= stamp_status;
            newest_reg        <= pulse_newest;
            ahead_two_reg     <= pulse_ahead_two;
            ahead_one_reg     <= pulse_ahead_one;
            now_reg           <= pulse_now;
            newest_bad_reg    <= newest_bad;
            ahead_two_bad_reg <= ahead_two_bad;
            ahead_one_bad_reg <= ahead_one_bad;
            idx_reg           <= slot_index;
        end
    end

    // Pulse ID check
    pts_check #(
        .PULSE_ID_BITS (PULSE_ID_BITS)
    ) u_check (
        .pulse_newest    (newest_reg),
        .pulse_ahead_two (ahead_two_reg),
        .pulse_ahead_one (ahead_one_reg),
        .pulse_now       (now_reg),
        .newest_bad      (newest_bad_reg),
        .ahead_two_bad   (ahead_two_bad_reg),
        .ahead_one_bad   (ahead_one_bad_reg),
        .result          (chk)
    );

    // Slot file
    always_comb
    begin
        slot_ctrl.wr         = advance & is_write;
        slot_ctrl.shift      = advance & is_fid;
        slot_ctrl.same_pulse = chk.same_pulse;
    end

    pts_slots #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (slot_ctrl),
        .wr_seconds (seconds_reg),
        .wr_nanos   (nanos_reg),
        .wr_status  (status_reg),
        .rd_idx     (idx_reg),
        .rd_seconds (slot_seconds),
        .rd_nanos   (slot_nanos),
        .rd_status  (slot_status)
    );

    // Saturating event counters
    always_comb
    begin
        same_total_next = same_total_reg;
        skip_total_next = skip_total_reg;
        if (is_fid && chk.same_hit && same_total_reg != COUNT_MAX)
        begin
            same_total_next = same_total_reg + COUNT_W'(1);
        end
        if (is_fid && chk.skip_hit && skip_total_reg != COUNT_MAX)
        begin
            skip_total_next = skip_total_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_total_reg <= '0;
            skip_total_reg <= '0;
        end
        else if (advance)
        begin
            same_total_reg <= same_total_next;
            skip_total_reg <= skip_total_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_seconds_reg <= is_read ? slot_seconds : '0;
            read_nanos_reg   <= is_read ? slot_nanos : '0;
            read_status_reg  <= is_read ? slot_status : STATUS_OK;
            error_flag_reg   <= is_fid & chk.err;
            same_out_reg     <= same_total_next;
            skip_out_reg     <= skip_total_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign read_seconds        = read_seconds_reg;
    assign read_nanos          = read_nanos_reg;
    assign read_status         = read_status_reg;
    assign error_flag          = error_flag_reg;
    assign same_pulse_total    = same_out_reg;
    assign skipped_pulse_total = skip_out_reg;

    // Checks
    `PTS_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall,
        (in_valid_reg && out_valid_reg && out_stall), "input stalled while a stage is free")
    `PTS_ASSERT_NEXT(a_err_only_fiducial, clk, rst_n, (advance && !is_fid),
        (!error_flag_reg), "error flag raised on a non-fiducial word")
    `PTS_ASSERT_NEXT(a_one_counter_step, clk, rst_n, 1'b1,
        (!((same_total_reg != $past(same_total_reg)) && (skip_total_reg != $past(skip_total_reg)))),
        "both event counters moved on one word")

endmodule
